// ===== sv/pfse_pkg.sv =====
package pfse_pkg;

    // Fixed field widths
    localparam int unsigned CHAN_W   = 12;
    localparam int unsigned TICK_W   = 15;
    localparam int unsigned SLOT_W   = 17;
    localparam int unsigned SPACE_W  = 21;
    localparam int unsigned BUDGET_W = 24;
    localparam int unsigned CFG_W    = 16;

    localparam logic [TICK_W-1:0]   CHUNK_MAX    = 15'h7FFF;
    localparam logic [BUDGET_W-1:0] BUDGET_FLOOR = 24'h800000;

    // Register reset values, the times in microseconds
    localparam logic             ACTIVE_HIGH_RST = 1'b1;
    localparam int unsigned      PULSE_US_RST    = 300;
    localparam int unsigned      SPACE_US_RST    = 4000;
    localparam int unsigned      FRAME_US_RST    = 22500;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ACTIVE_HIGH  = 2'd0;
    localparam t_cfg_idx CFG_PULSE_WIDTH  = 2'd1;
    localparam t_cfg_idx CFG_MIN_SPACE    = 2'd2;
    localparam t_cfg_idx CFG_MIN_FRAME    = 2'd3;

    typedef struct packed {
        logic [CHAN_W-1:0] channel_width_us;
        logic              last_channel;
    } t_chan;

    typedef struct packed {
        logic              first_level;
        logic [TICK_W-1:0] first_ticks;
        logic              second_level;
        logic [TICK_W-1:0] second_ticks;
        logic              frame_end;
    } t_sym;

    typedef struct packed {
        logic capture;
        logic emit_slot;
        logic calc_rem;
        logic emit_stop;
        logic emit_pad;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic stop_end;
        logic pad_end;
    } t_dp_sts;

endpackage

// ===== sv/pfse_stream_if.sv =====
interface pfse_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== sv/pfse_ctrl.sv =====
module pfse_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output pfse_pkg::t_dp_cmd o_cmd,
    input  pfse_pkg::t_dp_sts i_sts
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SLOT = 3'd1;
    localparam logic [2:0] S_REM  = 3'd2;
    localparam logic [2:0] S_STOP = 3'd3;
    localparam logic [2:0] S_PAD  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_out_free;
    logic       w_emit;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        w_emit  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SLOT;
                end
            end
            S_SLOT: begin
                if (w_out_free) begin
                    o_cmd.emit_slot = 1'b1;
                    w_emit          = 1'b1;
                    n_state         = i_sts.last ? S_REM : S_IDLE;
                end
            end
            S_REM: begin
                o_cmd.calc_rem = 1'b1;
                n_state        = S_STOP;
            end
            S_STOP: begin
                if (w_out_free) begin
                    o_cmd.emit_stop = 1'b1;
                    w_emit          = 1'b1;
                    n_state         = i_sts.stop_end ? S_IDLE : S_PAD;
                end
            end
            S_PAD: begin
                if (w_out_free) begin
                    o_cmd.emit_pad = 1'b1;
                    w_emit         = 1'b1;
                    n_state        = i_sts.pad_end ? S_IDLE : S_PAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

// ===== sv/pfse_dpath.sv =====
module pfse_dpath #(
    parameter int unsigned TICKS_PER_US = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  pfse_pkg::t_cfg_idx                  i_cfg_idx,
    input  logic [pfse_pkg::CFG_W-1:0]          i_cfg_data,
    input  pfse_pkg::t_chan                     i_chan,
    input  pfse_pkg::t_dp_cmd                   i_cmd,
    output pfse_pkg::t_dp_sts                   o_sts,
    output pfse_pkg::t_sym                      o_sym
);
    localparam logic [pfse_pkg::TICK_W-1:0] PULSE_RST =
        pfse_pkg::TICK_W'(pfse_pkg::PULSE_US_RST * TICKS_PER_US);
    localparam logic [pfse_pkg::SPACE_W-1:0] SPACE_RST =
        pfse_pkg::SPACE_W'(pfse_pkg::SPACE_US_RST * TICKS_PER_US);
    localparam logic [pfse_pkg::BUDGET_W-1:0] FRAME_RST =
        pfse_pkg::BUDGET_W'(pfse_pkg::FRAME_US_RST * TICKS_PER_US);
    localparam logic [pfse_pkg::BUDGET_W-1:0] CHUNK_W24 =
        pfse_pkg::BUDGET_W'(pfse_pkg::CHUNK_MAX);
    localparam logic [pfse_pkg::BUDGET_W-1:0] CHUNK2_W24 = CHUNK_W24 + CHUNK_W24;

    logic                              r_active_high;
    logic [pfse_pkg::TICK_W-1:0]       r_pulse_ticks;
    logic [pfse_pkg::SPACE_W-1:0]      r_space_ticks;
    logic [pfse_pkg::BUDGET_W-1:0]     r_frame_ticks;
    logic [pfse_pkg::BUDGET_W-1:0]     r_budget;
    logic [pfse_pkg::SLOT_W-1:0]       r_slot_ticks;
    logic                              r_last;
    logic [pfse_pkg::BUDGET_W-1:0]     r_rem;
    pfse_pkg::t_sym                    r_sym;

    logic [pfse_pkg::BUDGET_W-1:0]     w_cfg_frame;
    logic signed [pfse_pkg::SLOT_W:0]  w_gap;
    logic [pfse_pkg::TICK_W-1:0]       w_gap_ticks;
    logic signed [pfse_pkg::BUDGET_W:0] w_bsub;
    logic [pfse_pkg::BUDGET_W-1:0]     w_bnext;
    logic signed [pfse_pkg::BUDGET_W:0] w_rsub;
    logic                              w_raise;
    logic                              w_stop_end;
    logic                              w_pad_end;
    logic                              w_pad_full;

    assign w_cfg_frame = pfse_pkg::BUDGET_W'(32'(i_cfg_data) * TICKS_PER_US);

    // Idle part of a channel slot, clipped to one chunk
    assign w_gap = $signed({1'b0, r_slot_ticks}) - $signed({3'b000, r_pulse_ticks});
    always_comb begin
        if (w_gap < 0) begin
            w_gap_ticks = '0;
        end else if (w_gap > $signed({3'b000, pfse_pkg::CHUNK_MAX})) begin
            w_gap_ticks = pfse_pkg::CHUNK_MAX;
        end else begin
            w_gap_ticks = w_gap[pfse_pkg::TICK_W-1:0];
        end
    end

    // Budget minus slot, floored at the most negative budget
    assign w_bsub  = $signed({r_budget[pfse_pkg::BUDGET_W-1], r_budget})
                   - $signed({8'd0, r_slot_ticks});
    assign w_bnext = (w_bsub[pfse_pkg::BUDGET_W] && !w_bsub[pfse_pkg::BUDGET_W-1])
                   ? pfse_pkg::BUDGET_FLOOR : w_bsub[pfse_pkg::BUDGET_W-1:0];

    // Rest after stop pulse, raised to the minimum space
    assign w_rsub  = $signed({r_budget[pfse_pkg::BUDGET_W-1], r_budget})
                   - $signed({10'd0, r_pulse_ticks});
    assign w_raise = w_rsub < $signed({4'd0, r_space_ticks});

    assign w_stop_end = r_rem <= CHUNK_W24;
    assign w_pad_end  = r_rem <= CHUNK2_W24;
    assign w_pad_full = r_rem > CHUNK2_W24;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_high <= pfse_pkg::ACTIVE_HIGH_RST;
            r_pulse_ticks <= PULSE_RST;
            r_space_ticks <= SPACE_RST;
            r_frame_ticks <= FRAME_RST;
            r_budget      <= FRAME_RST;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pfse_pkg::CFG_ACTIVE_HIGH: r_active_high <= i_cfg_data[0];
                    pfse_pkg::CFG_PULSE_WIDTH: r_pulse_ticks <=
                        pfse_pkg::TICK_W'(32'(i_cfg_data[9:0]) * TICKS_PER_US);
                    pfse_pkg::CFG_MIN_SPACE: r_space_ticks <=
                        pfse_pkg::SPACE_W'(32'(i_cfg_data) * TICKS_PER_US);
                    pfse_pkg::CFG_MIN_FRAME: begin
                        r_frame_ticks <= w_cfg_frame;
                        r_budget      <= w_cfg_frame;
                    end
                    default: begin
                    end
                endcase
            end
            // take each slot off the budget; reload for the next frame once the last symbol goes out
            if (i_cmd.emit_slot) begin
                r_budget <= w_bnext;
            end else if ((i_cmd.emit_stop && w_stop_end) || (i_cmd.emit_pad && w_pad_end)) begin
                r_budget <= r_frame_ticks;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_slot_ticks <= pfse_pkg::SLOT_W'(32'(i_chan.channel_width_us) * TICKS_PER_US);
            r_last       <= i_chan.last_channel;
        end
        if (i_cmd.calc_rem) begin
            r_rem <= w_raise ? pfse_pkg::BUDGET_W'(r_space_ticks)
                             : w_rsub[pfse_pkg::BUDGET_W-1:0];
        end else if (i_cmd.emit_stop) begin
            r_rem <= w_stop_end ? '0 : r_rem - CHUNK_W24;
        end else if (i_cmd.emit_pad) begin
            r_rem <= w_pad_full ? r_rem - CHUNK2_W24 : '0;
        end

        priority if (i_cmd.emit_slot) begin
            r_sym.first_level  <= r_active_high;
            r_sym.first_ticks  <= r_pulse_ticks;
            r_sym.second_level <= !r_active_high;
            r_sym.second_ticks <= w_gap_ticks;
            r_sym.frame_end    <= 1'b0;
        end else if (i_cmd.emit_stop) begin
            r_sym.first_level  <= r_active_high;
            r_sym.first_ticks  <= r_pulse_ticks;
            r_sym.second_level <= !r_active_high;
            r_sym.second_ticks <= w_stop_end ? r_rem[pfse_pkg::TICK_W-1:0]
                                             : pfse_pkg::CHUNK_MAX;
            r_sym.frame_end    <= w_stop_end;
        end else if (i_cmd.emit_pad) begin
            r_sym.first_level  <= !r_active_high;
            r_sym.second_level <= !r_active_high;
            r_sym.frame_end    <= w_pad_end;
            if (w_pad_full) begin
                r_sym.first_ticks  <= pfse_pkg::CHUNK_MAX;
                r_sym.second_ticks <= pfse_pkg::CHUNK_MAX;
            end else if (!w_stop_end) begin
                r_sym.first_ticks  <= pfse_pkg::CHUNK_MAX;
                r_sym.second_ticks <= pfse_pkg::TICK_W'(r_rem - CHUNK_W24);
            end else begin
                r_sym.first_ticks  <= r_rem[pfse_pkg::TICK_W-1:0];
                r_sym.second_ticks <= '0;
            end
        end else begin
            r_sym <= r_sym;
        end
    end

    assign o_sts.last     = r_last;
    assign o_sts.stop_end = w_stop_end;
    assign o_sts.pad_end  = w_pad_end;
    assign o_sym          = r_sym;
endmodule

// ===== sv/ppm_frame_symbol_encoder_unit.sv =====
// PPM frame symbol encoder. Each channel request (slot width in microseconds and a
// last-channel flag) turns into one two-phase line symbol: the active level for the
// start pulse, then the idle level for the rest of the slot. A signed tick budget,
// loaded from the minimum frame length, loses each slot's time; after the last
// channel the block sends a stop pulse whose idle phase is the rest of the budget,
// raised to at least the minimum space, and cut into 32767-tick chunks that spill
// into all-idle padding symbols. One microsecond is TICKS_PER_US ticks. Timing: an
// accepted request is captured, then the slot state writes its symbol into the
// output register once that register is free and the controller returns to idle;
// after the last channel it instead goes on through the remainder and stop states
// to the stop symbol, then emits one padding symbol per cycle while the output
// register is free (up to 16 padding symbols with the widest settings and
// TICKS_PER_US at 16). Output back-pressure stretches each emit. A new channel
// request is taken as soon as the previous one has handed off its final symbol,
// even while that symbol still waits in the output register. Configuration writes
// are applied at once; writing the minimum frame length restarts the budget of the
// current frame, unless a slot or frame-ending symbol is emitted at the same time.
module ppm_frame_symbol_encoder_unit #(
    parameter int unsigned TICKS_PER_US = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  pfse_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [pfse_pkg::CFG_W-1:0] i_cfg_data,
    pfse_stream_if.sink                i_chan,
    pfse_stream_if.source              o_sym
);
    pfse_pkg::t_dp_cmd w_cmd;
    pfse_pkg::t_dp_sts w_sts;
    pfse_pkg::t_chan   w_chan;
    pfse_pkg::t_sym    w_sym;
    logic              w_in_ready;
    logic              w_out_valid;

    assign w_chan = i_chan.data;

    // sequence the request: capture, emit slot symbol, then after the last channel stop and padding
    pfse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_chan.valid),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_sym.ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // hold configuration, budget, remaining idle time and the output register
    pfse_dpath #(
        .TICKS_PER_US (TICKS_PER_US)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_chan     (w_chan),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_sym      (w_sym)
    );

    assign i_chan.ready = w_in_ready;
    assign o_sym.valid  = w_out_valid;
    assign o_sym.data   = w_sym;
endmodule

// ===== tb/ppm_frame_symbol_encoder_unit_tb.sv =====
module ppm_frame_symbol_encoder_unit_tb;
    import pfse_pkg::*;

    localparam int unsigned TICKS_PER_US = 10;
    localparam longint      TPU          = TICKS_PER_US;
    localparam longint      CHUNK_TICKS  = longint'(CHUNK_MAX);
    localparam longint      BUDGET_LOW   = -64'sd8388608;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          HOLD_AT_COUNT  = 60;
    localparam int          DRAIN_CYCLES   = 24;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_cfg_we   = 1'b0;
    t_cfg_idx         i_cfg_idx  = CFG_ACTIVE_HIGH;
    logic [CFG_W-1:0] i_cfg_data = '0;

    pfse_stream_if #(.t_data(t_chan)) chan_if ();
    pfse_stream_if #(.t_data(t_sym))  sym_if ();

    ppm_frame_symbol_encoder_unit #(
        .TICKS_PER_US(TICKS_PER_US)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_chan     (chan_if),
        .o_sym      (sym_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Encoder shadow: register copies and the running frame budget in ticks
    int     cfg_active_high;
    int     cfg_pulse_us;
    int     cfg_space_us;
    int     cfg_frame_us;
    longint frame_budget;

    t_chan  pending_chans[$];
    t_sym   sym_expect_q[$];

    // Handshake pacing state
    bit     drv_idle_en;
    bit     mon_idle_en;
    int     drv_gap;
    int     mon_stall;
    int     mon_hold;
    int     symbols_seen;
    int     mismatches;
    int     quiet_cycles;

    initial begin
        chan_if.valid = 1'b0;
        chan_if.data  = '0;
        sym_if.ready  = 1'b0;
    end

    function automatic longint clip_ticks(longint v);
        if (v < 0)
            return 0;
        if (v > CHUNK_TICKS)
            return CHUNK_TICKS;
        return v;
    endfunction

    function automatic void push_symbol(logic l0, longint d0, logic l1, longint d1, logic fin);
        t_sym s;
        s.first_level  = l0;
        s.first_ticks  = TICK_W'(clip_ticks(d0));
        s.second_level = l1;
        s.second_ticks = TICK_W'(clip_ticks(d1));
        s.frame_end    = fin;
        sym_expect_q.push_back(s);
    endfunction

    // Work out every symbol one channel request produces and advance the budget.
    function automatic void encode_channel(t_chan req);
        logic   act;
        logic   idle;
        longint pulse;
        longint slot;
        longint space;
        longint rest;
        longint d0;
        longint d1;
        act   = cfg_active_high[0];
        idle  = ~act;
        pulse = cfg_pulse_us * TPU;
        slot  = longint'(req.channel_width_us) * TPU;
        space = cfg_space_us * TPU;

        // Slot symbol: start pulse, then idle for the rest of the slot
        push_symbol(act, pulse, idle, slot - pulse, 1'b0);

        rest = frame_budget - slot;
        if (rest < BUDGET_LOW)
            rest = BUDGET_LOW;
        if (!req.last_channel) begin
            frame_budget = rest;
            return;
        end

        // Stop pulse carries the first chunk of the frame gap
        rest = rest - pulse;
        if (rest < space)
            rest = space;
        d1   = (rest > CHUNK_TICKS) ? CHUNK_TICKS : rest;
        rest = rest - d1;
        push_symbol(act, pulse, idle, d1, rest <= 0);

        // Spill the remaining gap into all-idle padding symbols
        while (rest > 0) begin
            d0   = (rest > CHUNK_TICKS) ? CHUNK_TICKS : rest;
            rest = rest - d0;
            d1   = (rest > CHUNK_TICKS) ? CHUNK_TICKS : rest;
            rest = rest - d1;
            push_symbol(idle, d0, idle, d1, rest <= 0);
        end
        frame_budget = cfg_frame_us * TPU;
    endfunction

    function automatic void check_symbol(t_sym got);
        t_sym want;
        if (sym_expect_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("symbol %0d: nothing pending, got %0b/%0d %0b/%0d end %0b",
                         symbols_seen, got.first_level, got.first_ticks,
                         got.second_level, got.second_ticks, got.frame_end);
            return;
        end
        want = sym_expect_q.pop_front();
        if (got.first_level !== want.first_level || got.first_ticks !== want.first_ticks ||
            got.second_level !== want.second_level ||
            got.second_ticks !== want.second_ticks || got.frame_end !== want.frame_end) begin
            mismatches++;
            if (mismatches <= 10)
                $display("symbol %0d: expected %0b/%0d %0b/%0d end %0b, got %0b/%0d %0b/%0d end %0b",
                         symbols_seen, want.first_level, want.first_ticks,
                         want.second_level, want.second_ticks, want.frame_end,
                         got.first_level, got.first_ticks,
                         got.second_level, got.second_ticks, got.frame_end);
        end
    endfunction

    // Request driver: present the next pending channel, holding it until taken.
    // After each accepted request, draw the idle gap before the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chan_if.valid <= 1'b0;
            drv_gap = 0;
        end else begin
            if (chan_if.valid && chan_if.ready) begin
                encode_channel(chan_if.data);
                drv_gap = drv_idle_en ? $urandom_range(0, 7) : 0;
            end
            if (!chan_if.valid || chan_if.ready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    chan_if.valid <= 1'b0;
                end else if (pending_chans.size() > 0) begin
                    chan_if.data  <= pending_chans.pop_front();
                    chan_if.valid <= 1'b1;
                end else begin
                    chan_if.valid <= 1'b0;
                end
            end
        end
    end

    // Symbol monitor: check each accepted symbol, then stall ready at random.
    // Once, hold ready low for a long stretch so the encoder backs up and
    // stalls its request side while the driver keeps offering.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sym_if.ready <= 1'b0;
            mon_stall = 0;
            mon_hold  = 0;
        end else begin
            if (sym_if.valid && sym_if.ready) begin
                check_symbol(sym_if.data);
                symbols_seen++;
                mon_stall = mon_idle_en ? $urandom_range(0, 7) : 0;
                if (symbols_seen == HOLD_AT_COUNT)
                    mon_hold = HOLD_CYCLES;
            end
            if (mon_hold > 0) begin
                mon_hold--;
                sym_if.ready <= 1'b0;
            end else if (mon_stall > 0) begin
                mon_stall--;
                sym_if.ready <= 1'b0;
            end else begin
                sym_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles in which neither side completes a transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (chan_if.valid && chan_if.ready) || (sym_if.valid && sym_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ppm_frame_symbol_encoder_unit test failed");
            $finish;
        end
    end

    task automatic cfg_write(t_cfg_idx idx, int value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(value);
        case (idx)
            CFG_ACTIVE_HIGH: cfg_active_high = value & 1;
            CFG_PULSE_WIDTH: cfg_pulse_us    = value & 'h3FF;
            CFG_MIN_SPACE:   cfg_space_us    = value & 'hFFFF;
            CFG_MIN_FRAME: begin
                cfg_frame_us = value & 'hFFFF;
                frame_budget = cfg_frame_us * TPU;
            end
            default: ;
        endcase
    endtask

    task automatic cfg_release();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_chan(int width_us, bit last);
        t_chan c;
        c.channel_width_us = CHAN_W'(width_us);
        c.last_channel     = last;
        pending_chans.push_back(c);
    endtask

    // Wait until every request went in and every symbol came out, then let
    // the pipeline settle before touching the registers.
    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (pending_chans.size() != 0 || chan_if.valid || sym_expect_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic int pick_width();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 4095);
        return $urandom_range(700, 2100);
    endfunction

    initial begin
        int sum_us;
        int frame_len;
        int phase_items;

        cfg_active_high = int'(ACTIVE_HIGH_RST);
        cfg_pulse_us    = PULSE_US_RST;
        cfg_space_us    = SPACE_US_RST;
        cfg_frame_us    = FRAME_US_RST;
        frame_budget    = cfg_frame_us * TPU;
        drv_idle_en     = 1'b1;
        mon_idle_en     = 1'b1;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: short slot, slot equal to the pulse, widest slot,
        // then a stop pulse whose gap spills into padding
        add_chan(0, 1'b0);
        add_chan(300, 1'b0);
        add_chan(4095, 1'b0);
        add_chan(1500, 1'b1);
        wait_drained();

        // All-zero settings with inverted levels: empty gap, negative rest
        cfg_write(CFG_ACTIVE_HIGH, 0);
        cfg_write(CFG_PULSE_WIDTH, 0);
        cfg_write(CFG_MIN_SPACE, 0);
        cfg_write(CFG_MIN_FRAME, 0);
        cfg_release();
        add_chan(0, 1'b1);
        add_chan(4095, 1'b1);
        add_chan(1, 1'b0);
        add_chan(2, 1'b1);
        wait_drained();

        // Widest settings: longest padding run
        cfg_write(CFG_ACTIVE_HIGH, 1);
        cfg_write(CFG_PULSE_WIDTH, 1023);
        cfg_write(CFG_MIN_SPACE, 65535);
        cfg_write(CFG_MIN_FRAME, 65535);
        cfg_release();
        add_chan(0, 1'b1);
        add_chan(4095, 1'b0);
        add_chan(4095, 1'b1);
        wait_drained();

        // Gap of one full chunk plus a little: last padding chunk fits in
        // the first phase and leaves the second phase empty
        cfg_write(CFG_PULSE_WIDTH, 1);
        cfg_write(CFG_MIN_SPACE, 0);
        cfg_write(CFG_MIN_FRAME, 3278);
        cfg_release();
        add_chan(0, 1'b1);
        add_chan(100, 1'b0);
        wait_drained();
        // Rewrite the frame length mid-frame: the budget restarts
        cfg_write(CFG_MIN_FRAME, 3278);
        cfg_release();
        add_chan(0, 1'b1);
        wait_drained();

        // Budget underflow: zero frame length and a long run of wide slots
        // drive the budget into its lower saturation
        drv_idle_en = 1'b0;
        cfg_write(CFG_ACTIVE_HIGH, $urandom_range(0, 1));
        cfg_write(CFG_PULSE_WIDTH, $urandom_range(0, 1023));
        cfg_write(CFG_MIN_SPACE, $urandom_range(0, 3000));
        cfg_write(CFG_MIN_FRAME, 0);
        cfg_release();
        sum_us = 0;
        while (sum_us < 840000) begin
            frame_len = $urandom_range(3900, 4095);
            sum_us += frame_len;
            add_chan(frame_len, 1'b0);
        end
        repeat (4) add_chan($urandom_range(0, 4095), 1'b0);
        add_chan($urandom_range(0, 4095), 1'b1);
        wait_drained();

        // Random phases: fresh settings, then frames of random length; some
        // phases stop mid-frame so the next settings land inside a frame
        for (int p = 0; p < 6; p++) begin
            drv_idle_en = ($urandom_range(0, 3) != 0);
            mon_idle_en = ($urandom_range(0, 3) != 0);
            if (p == 0 || $urandom_range(0, 1))
                cfg_write(CFG_ACTIVE_HIGH, $urandom_range(0, 1));
            if (p == 0 || $urandom_range(0, 1))
                case ($urandom_range(0, 3))
                    0:       cfg_write(CFG_PULSE_WIDTH, 0);
                    1:       cfg_write(CFG_PULSE_WIDTH, 1023);
                    default: cfg_write(CFG_PULSE_WIDTH, $urandom_range(0, 1023));
                endcase
            if (p == 0 || $urandom_range(0, 1))
                case ($urandom_range(0, 4))
                    0:       cfg_write(CFG_MIN_SPACE, 0);
                    1:       cfg_write(CFG_MIN_SPACE, 65535);
                    default: cfg_write(CFG_MIN_SPACE, $urandom_range(0, 8000));
                endcase
            if (p == 0 || $urandom_range(0, 1))
                case ($urandom_range(0, 4))
                    0:       cfg_write(CFG_MIN_FRAME, 0);
                    1:       cfg_write(CFG_MIN_FRAME, 65535);
                    default: cfg_write(CFG_MIN_FRAME, $urandom_range(5000, 30000));
                endcase
            cfg_release();

            phase_items = 0;
            while (phase_items < 6) begin
                frame_len = $urandom_range(1, 10);
                for (int k = 0; k < frame_len; k++)
                    add_chan(pick_width(), k == frame_len - 1);
                phase_items += frame_len;
            end
            // Drop the frame end now and then so the phase ends mid-frame
            if ($urandom_range(0, 2) == 0)
                add_chan(pick_width(), 1'b0);
            wait_drained();
        end

        if (mismatches == 0 && sym_expect_q.size() == 0)
            $display("ppm_frame_symbol_encoder_unit test passed");
        else
            $display("ppm_frame_symbol_encoder_unit test failed");
        $finish;
    end

endmodule
